### rtl/masked_lut_recolor_pixel_defines.svh
// Assertion macros shared by the recolor pipeline modules.
`ifndef MASKED_LUT_RECOLOR_PIXEL_DEFINES_SVH
`define MASKED_LUT_RECOLOR_PIXEL_DEFINES_SVH

// Checks that pre implies post in the same cycle.
`define MLRP_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Checks that pre implies post in the next cycle.
`define MLRP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/mlrp_pkg.sv
// Types and constants of the masked lookup table recolor block.
`default_nettype none

package mlrp_pkg;

  localparam int unsigned NUM_CH = 3;

  // Division by 3, 255 and 100 through a reciprocal multiply and a shift.
  localparam logic [9:0]  DIV3_MUL     = 10'd683;
  localparam int unsigned DIV3_SHIFT   = 11;
  localparam logic [15:0] DIV255_MUL   = 16'd32897;
  localparam int unsigned DIV255_SHIFT = 23;
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic [7:0] COLOR_MAX    = 8'd255;
  localparam logic [6:0] STRENGTH_MAX = 7'd100;
  localparam logic [6:0] STRENGTH_RST = 7'd100;

  typedef enum logic [2:0] {
    CFG_REGION_TOP    = 3'd0,
    CFG_REGION_BOTTOM = 3'd1,
    CFG_REGION_LEFT   = 3'd2,
    CFG_REGION_RIGHT  = 3'd3,
    CFG_STRENGTH      = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  // Channel 0 is blue, 1 green, 2 red, matching the table entry layout.
  typedef logic [NUM_CH-1:0][7:0] color_t;

  typedef struct packed {
    color_t     color;
    logic [7:0] alpha;
    logic [7:0] gray;
    logic       in_region;
  } pix_t;

endpackage

`default_nettype wire

### rtl/mlrp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mlrp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 262144,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/mlrp_color_pipe.sv
// Alpha blend and strength mix pipeline behind the table read.
`default_nettype none

`include "masked_lut_recolor_pixel_defines.svh"

module mlrp_color_pipe
  import mlrp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire pix_t       pix_i,
  input  wire logic [23:0] entry_i,
  input  wire logic [6:0] strength_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output color_t          out_color_o,
  output logic [7:0]      out_alpha_o,
  output logic            out_recolored_o
);

  // Each stage loads when it is empty or its content moves on.
  logic ld2, ld3, ld4, ld_out;

  logic s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  pix_t s2_pix_q, s3_pix_q, s4_pix_q;

  logic [NUM_CH-1:0][15:0] s2_keep_q, s2_tab_q;
  logic [NUM_CH-1:0][15:0] s2_keep_d, s2_tab_d;
  color_t                  s3_blend_q, s3_blend_d;
  logic [NUM_CH-1:0][14:0] s4_mix_q, s4_orig_q;
  logic [NUM_CH-1:0][14:0] s4_mix_d, s4_orig_d;
  color_t                  out_color_q, out_color_d;
  logic [7:0]              out_alpha_q;
  logic                    out_recolored_q;

  logic [NUM_CH-1:0][16:0] blend_sum;
  logic [NUM_CH-1:0][33:0] blend_prod;
  logic [NUM_CH-1:0][10:0] blend_quo;
  logic [NUM_CH-1:0][15:0] mix_sum;
  logic [NUM_CH-1:0][29:0] mix_prod;

  assign ld_out  = !out_valid_q || !out_stall_i;
  assign ld4     = !s4_valid_q || ld_out;
  assign ld3     = !s3_valid_q || ld4;
  assign ld2     = !s2_valid_q || ld3;
  assign ready_o = ld2;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s2_keep_d[ch] = 16'(pix_i.color[ch]) * 16'(COLOR_MAX - pix_i.gray);
      s2_tab_d[ch]  = 16'(entry_i[8*ch +: 8]) * 16'(pix_i.gray);

      blend_sum[ch]  = 17'(s2_keep_q[ch]) + 17'(s2_tab_q[ch]);
      blend_prod[ch] = 34'(blend_sum[ch]) * 34'(DIV255_MUL);
      blend_quo[ch]  = blend_prod[ch][DIV255_SHIFT +: 11];
      s3_blend_d[ch] = (blend_quo[ch] > 11'(COLOR_MAX)) ? COLOR_MAX : blend_quo[ch][7:0];

      s4_mix_d[ch]  = 15'(s3_blend_q[ch]) * 15'(strength_i);
      s4_orig_d[ch] = 15'(s3_pix_q.color[ch]) * 15'(STRENGTH_MAX - strength_i);

      mix_sum[ch]     = 16'(s4_mix_q[ch]) + 16'(s4_orig_q[ch]);
      mix_prod[ch]    = 30'(mix_sum[ch]) * 30'(DIV100_MUL);
      out_color_d[ch] = s4_pix_q.in_region ? mix_prod[ch][DIV100_SHIFT +: 8]
                                           : s4_pix_q.color[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld2) begin
        s2_valid_q <= valid_i;
      end
      if (ld3) begin
        s3_valid_q <= s2_valid_q;
      end
      if (ld4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (ld_out) begin
        out_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      s2_pix_q  <= pix_i;
      s2_keep_q <= s2_keep_d;
      s2_tab_q  <= s2_tab_d;
    end
    if (ld3) begin
      s3_pix_q   <= s2_pix_q;
      s3_blend_q <= s3_blend_d;
    end
    if (ld4) begin
      s4_pix_q  <= s3_pix_q;
      s4_mix_q  <= s4_mix_d;
      s4_orig_q <= s4_orig_d;
    end
    if (ld_out) begin
      out_color_q     <= out_color_d;
      out_alpha_q     <= s4_pix_q.alpha;
      out_recolored_q <= s4_pix_q.in_region;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_color_o     = out_color_q;
  assign out_alpha_o     = out_alpha_q;
  assign out_recolored_o = out_recolored_q;

  `MLRP_ASSERT_NEXT(a_s4_hold, s4_valid_q && !ld4, s4_valid_q && $stable(s4_pix_q),
                    "stage 4 lost or changed a held transaction")
  `MLRP_ASSERT_NEXT(a_s3_to_s4, ld4 && s3_valid_q, s4_valid_q,
                    "transaction dropped between stage 3 and stage 4")
  `MLRP_ASSERT_NOW(a_full_when_busy, !ready_o,
                   s2_valid_q && s3_valid_q && s4_valid_q && out_valid_q,
                   "pipeline refused a transaction while a stage was empty")

endmodule

`default_nettype wire

### rtl/masked_lut_recolor_pixel.sv
// Top level of the masked lookup table recolor block.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | input     | in_valid_i/in_stall_o| kind, col, row, table_index, colors
//   out     | output    | out_valid_o/out_stall_i | out colors, out_alpha, recolored
//   cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One transaction is accepted per clock when the output is not blocked.
// After its accepting edge a pixel passes the table read register, then two blend
// stages and two mix stages, each bounded by one multiplier.
// A load writes its table entry at the accepting edge and gives no result.
// Stages hold while the output stalls and empty stages still fill, so input
// keeps flowing until every stage is occupied. Reset clears control only.
`default_nettype none

`include "masked_lut_recolor_pixel_defines.svh"

module masked_lut_recolor_pixel
  import mlrp_pkg::*;
#(
  parameter int unsigned TABLE_SIDE = 512,
  localparam int unsigned TABLE_DEPTH = TABLE_SIDE * TABLE_SIDE,
  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [11:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              kind_i,
  input  wire logic [11:0]       col_i,
  input  wire logic [11:0]       row_i,
  input  wire logic [ADDR_W-1:0] table_index_i,
  input  wire logic [7:0]        blue_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        alpha_i,
  input  wire logic [7:0]        mask_blue_i,
  input  wire logic [7:0]        mask_green_i,
  input  wire logic [7:0]        mask_red_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             out_blue_o,
  output logic [7:0]             out_green_o,
  output logic [7:0]             out_red_o,
  output logic [7:0]             out_alpha_o,
  output logic                   recolored_o
);

  logic [11:0] region_top_q, region_bottom_q, region_left_q, region_right_q;
  logic [6:0]  strength_q;
  logic [6:0]  strength_sat;

  logic        s1_valid_q;
  pix_t        s1_pix_q, s1_pix_d;
  logic        ld1, pipe_ready, in_accept;
  logic [9:0]  mask_sum;
  logic [19:0] gray_prod;
  logic [8:0]  lut_x, lut_y;
  logic [ADDR_W-1:0] lut_addr;
  logic [23:0] ram_rdata;
  color_t      out_color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_top_q    <= '0;
      region_bottom_q <= '0;
      region_left_q   <= '0;
      region_right_q  <= '0;
      strength_q      <= STRENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_REGION_TOP:    region_top_q    <= cfg_data_i;
        CFG_REGION_BOTTOM: region_bottom_q <= cfg_data_i;
        CFG_REGION_LEFT:   region_left_q   <= cfg_data_i;
        CFG_REGION_RIGHT:  region_right_q  <= cfg_data_i;
        CFG_STRENGTH:      strength_q      <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign strength_sat = (strength_q > STRENGTH_MAX) ? STRENGTH_MAX : strength_q;

  assign ld1        = !s1_valid_q || pipe_ready;
  assign in_stall_o = !ld1;
  assign in_accept  = in_valid_i && ld1;

  // Mask average: the sum of three channels times the reciprocal of three.
  assign mask_sum  = 10'(mask_blue_i) + 10'(mask_green_i) + 10'(mask_red_i);
  assign gray_prod = 20'(mask_sum) * 20'(DIV3_MUL);

  // The table is a square image; blue picks the tile, red and green the cell.
  assign lut_x    = {blue_i[4:2], red_i[7:2]};
  assign lut_y    = {blue_i[7:5], green_i[7:2]};
  assign lut_addr = ADDR_W'(lut_y) * ADDR_W'(TABLE_SIDE) + ADDR_W'(lut_x);

  always_comb begin
    s1_pix_d.color     = {red_i, green_i, blue_i};
    s1_pix_d.alpha     = alpha_i;
    s1_pix_d.gray      = gray_prod[DIV3_SHIFT +: 8];
    s1_pix_d.in_region = (row_i >= region_top_q) && (row_i <= region_bottom_q) &&
                         (col_i >= region_left_q) && (col_i <= region_right_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ld1) begin
      s1_valid_q <= in_accept && (kind_e'(kind_i) == KIND_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_pix_q <= s1_pix_d;
    end
  end

  // A load writes at its accepting edge, so a pixel taken on a later edge
  // already reads the new entry; both never share one edge.
  mlrp_ram #(
    .WIDTH (24),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (in_accept && (kind_e'(kind_i) == KIND_LOAD)),
    .waddr_i (table_index_i),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (ld1),
    .raddr_i (lut_addr),
    .rdata_o (ram_rdata)
  );

  mlrp_color_pipe u_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s1_valid_q),
    .ready_o         (pipe_ready),
    .pix_i           (s1_pix_q),
    .entry_i         (ram_rdata),
    .strength_i      (strength_sat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_color_o     (out_color),
    .out_alpha_o     (out_alpha_o),
    .out_recolored_o (recolored_o)
  );

  assign out_blue_o  = out_color[0];
  assign out_green_o = out_color[1];
  assign out_red_o   = out_color[2];

  `MLRP_ASSERT_NEXT(a_pixel_enters, in_accept && (kind_e'(kind_i) == KIND_PIXEL),
                    s1_valid_q, "accepted pixel transaction did not enter the pipeline")
  `MLRP_ASSERT_NEXT(a_load_no_result, in_accept && (kind_e'(kind_i) == KIND_LOAD),
                    !s1_valid_q, "load transaction entered the result pipeline")
  `MLRP_ASSERT_NEXT(a_read_hold, s1_valid_q && in_stall_o,
                    s1_valid_q && $stable(ram_rdata),
                    "table read data changed while its pixel was held")

endmodule

`default_nettype wire

### sim/masked_lut_recolor_pixel_tb.sv
// Self-checking testbench for the masked lookup table recolor block.
`timescale 1ns / 1ps

module masked_lut_recolor_pixel_tb;
  import mlrp_pkg::*;

  localparam int unsigned LUT_DEPTH      = 512 * 512;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 105;
  localparam int unsigned MAX_PRINTS     = 40;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] col;
    logic [11:0] row;
    logic [17:0] index;
    logic [7:0]  b, g, r, a;
    logic [7:0]  mb, mg, mr;
  } item_t;

  typedef struct packed {
    logic [7:0] b, g, r, a;
    logic       rec;
  } pix_result_t;

  typedef enum logic { STEP_ITEM, STEP_CFG } step_e;

  typedef struct packed {
    step_e       op;
    cfg_idx_e    cfg_sel;
    logic [11:0] cfg_val;
    item_t       item;
    logic        typed;
    pix_result_t want;
  } dir_step_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [11:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  kind_e       kind;
  logic [11:0] col;
  logic [11:0] row;
  logic [17:0] table_index;
  logic [7:0]  blue, green, red, alpha;
  logic [7:0]  mask_blue, mask_green, mask_red;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_blue, out_green, out_red, out_alpha;
  logic        recolored;

  // Shadow of the block's table and registers.
  logic [23:0] color_lut [0:LUT_DEPTH-1];
  bit          slot_loaded [0:LUT_DEPTH-1];
  int unsigned loaded_slots [$];
  logic [11:0] cur_top, cur_bottom, cur_left, cur_right;
  logic [6:0]  cur_strength;

  pix_result_t pending_pixels [$];
  pix_result_t head;
  dir_step_t   steps [$];
  int unsigned mismatch_count = 0;
  int unsigned accepted_items = 0;
  int unsigned burst_left = 20;
  int unsigned quiet_cycles = 0;
  int unsigned holds_done = 0;

  masked_lut_recolor_pixel DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .col_i         (col),
    .row_i         (row),
    .table_index_i (table_index),
    .blue_i        (blue),
    .green_i       (green),
    .red_i         (red),
    .alpha_i       (alpha),
    .mask_blue_i   (mask_blue),
    .mask_green_i  (mask_green),
    .mask_red_i    (mask_red),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_blue_o    (out_blue),
    .out_green_o   (out_green),
    .out_red_o     (out_red),
    .out_alpha_o   (out_alpha),
    .recolored_o   (recolored)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The table is addressed by x = {blue[4:2], red[7:2]} and y = {blue[7:5], green[7:2]}.
  function automatic logic [17:0] slot_of(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    return {b[7:5], g[7:2], b[4:2], r[7:2]};
  endfunction

  function automatic pix_result_t recolor_predict(item_t it);
    pix_result_t res;
    logic [23:0] entry;
    int unsigned gray, pct, blended;
    int unsigned own [3];
    int unsigned lut [3];
    int unsigned mixed [3];
    res = '{b: it.b, g: it.g, r: it.r, a: it.a, rec: 1'b0};
    if (it.row >= cur_top && it.row <= cur_bottom &&
        it.col >= cur_left && it.col <= cur_right) begin
      entry = color_lut[slot_of(it.b, it.g, it.r)];
      gray = it.mb;
      gray += it.mg;
      gray += it.mr;
      gray /= 3;
      pct = (cur_strength > STRENGTH_MAX) ? 100 : cur_strength;
      own = '{it.b, it.g, it.r};
      lut = '{entry[7:0], entry[15:8], entry[23:16]};
      for (int k = 0; k < 3; k++) begin
        blended = (own[k] * (255 - gray) + lut[k] * gray) / 255;
        if (blended > 255) blended = 255;
        mixed[k] = (blended * pct + own[k] * (100 - pct)) / 100;
      end
      res.b = 8'(mixed[0]);
      res.g = 8'(mixed[1]);
      res.r = 8'(mixed[2]);
      res.rec = 1'b1;
    end
    return res;
  endfunction

  function automatic dir_step_t item_step(kind_e k, logic [11:0] c, logic [11:0] rw,
      logic [17:0] index, logic [23:0] bgr, logic [7:0] a, logic [23:0] mask);
    dir_step_t st;
    st = '0;
    st.op = STEP_ITEM;
    st.item.kind = k;
    st.item.col = c;
    st.item.row = rw;
    st.item.index = index;
    {st.item.b, st.item.g, st.item.r} = bgr;
    st.item.a = a;
    {st.item.mb, st.item.mg, st.item.mr} = mask;
    return st;
  endfunction

  function automatic dir_step_t typed_as(dir_step_t st, logic [23:0] bgr, logic rec);
    st.typed = 1'b1;
    {st.want.b, st.want.g, st.want.r} = bgr;
    st.want.a = st.item.a;
    st.want.rec = rec;
    return st;
  endfunction

  function automatic dir_step_t cfg_step(cfg_idx_e sel, logic [11:0] val);
    dir_step_t st;
    st = '0;
    st.op = STEP_CFG;
    st.cfg_sel = sel;
    st.cfg_val = val;
    return st;
  endfunction

  function automatic logic [11:0] pick_coord(logic [11:0] lo, logic [11:0] hi);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return (lo <= hi) ? 12'($urandom_range(lo, hi)) : 12'($urandom);
      5: return lo;
      6: return hi;
      7: return lo - 12'd1;
      8: return hi + 12'd1;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic send_item(item_t it, logic typed, pix_result_t want);
    in_valid    <= 1'b1;
    kind        <= it.kind;
    col         <= it.col;
    row         <= it.row;
    table_index <= it.index;
    blue        <= it.b;
    green       <= it.g;
    red         <= it.r;
    alpha       <= it.a;
    mask_blue   <= it.mb;
    mask_green  <= it.mg;
    mask_red    <= it.mr;
    do @(posedge clk); while (in_stall);
    accepted_items++;
    if (it.kind == KIND_LOAD) begin
      color_lut[it.index] = {it.r, it.g, it.b};
      if (!slot_loaded[it.index]) begin
        slot_loaded[it.index] = 1'b1;
        loaded_slots.push_back(it.index);
      end
    end else begin
      pending_pixels.push_back(typed ? want : recolor_predict(it));
    end
  endtask

  // Called right after an accepted transaction; ends a burst with a gap.
  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Loads give no result, so only pending pixel results are awaited before the idle tail.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e sel, logic [11:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      CFG_REGION_TOP:    cur_top = val;
      CFG_REGION_BOTTOM: cur_bottom = val;
      CFG_REGION_LEFT:   cur_left = val;
      CFG_REGION_RIGHT:  cur_right = val;
      CFG_STRENGTH:      cur_strength = val[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(logic [11:0] top, logic [11:0] bottom, logic [11:0] left,
      logic [11:0] right, logic [11:0] pct);
    settle();
    write_reg(CFG_REGION_TOP, top);
    write_reg(CFG_REGION_BOTTOM, bottom);
    write_reg(CFG_REGION_LEFT, left);
    write_reg(CFG_REGION_RIGHT, right);
    write_reg(CFG_STRENGTH, pct);
  endtask

  // Mostly pixels whose table entry is already loaded; an unloaded entry is
  // loaded right before the pixel that needs it. Stray loads act as noise.
  task automatic random_traffic(int unsigned count);
    item_t       it;
    item_t       fill;
    logic [17:0] slot;
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < count) begin
      it.kind  = KIND_PIXEL;
      it.col   = pick_coord(cur_left, cur_right);
      it.row   = pick_coord(cur_top, cur_bottom);
      it.index = 18'($urandom);
      it.a     = 8'($urandom);
      pick = $urandom_range(0, 7);
      {it.mb, it.mg, it.mr} = (pick == 0) ? 24'h000000 :
                              (pick == 1) ? 24'hFFFFFF : 24'($urandom);
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
        it.kind = KIND_LOAD;
        {it.b, it.g, it.r} = 24'($urandom);
      end else if (pick < 12 && loaded_slots.size() != 0) begin
        slot = 18'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
        it.b = {slot[17:15], slot[8:6], 2'($urandom)};
        it.g = {slot[14:9], 2'($urandom)};
        it.r = {slot[5:0], 2'($urandom)};
      end else if (pick == 14) begin
        {it.b, it.g, it.r} = 24'h000000;
      end else if (pick == 15) begin
        {it.b, it.g, it.r} = 24'hFFFFFF;
      end else begin
        {it.b, it.g, it.r} = 24'($urandom);
      end
      if (it.kind == KIND_PIXEL && !slot_loaded[slot_of(it.b, it.g, it.r)]) begin
        fill = it;
        fill.kind = KIND_LOAD;
        fill.index = slot_of(it.b, it.g, it.r);
        {fill.b, fill.g, fill.r} = 24'($urandom);
        send_item(fill, 1'b0, '0);
        pace_sender();
        sent++;
      end
      send_item(it, 1'b0, '0);
      pace_sender();
      sent++;
    end
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t ns: %s got %0h, wanted %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result, blue", out_blue, 8'h00);
      end else begin
        head = pending_pixels.pop_front();
        if (out_blue !== head.b) report_mismatch("out_blue", out_blue, head.b);
        if (out_green !== head.g) report_mismatch("out_green", out_green, head.g);
        if (out_red !== head.r) report_mismatch("out_red", out_red, head.r);
        if (out_alpha !== head.a) report_mismatch("out_alpha", out_alpha, head.a);
        if (recolored !== head.rec)
          report_mismatch("recolored", 8'(recolored), 8'(head.rec));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("masked_lut_recolor_pixel: mismatch");
      $finish;
    end
  end

  // Receiver: random stall segments, plus two long hold-offs that let the
  // pipeline fill up and push back on the sender.
  initial begin
    int unsigned seg_mode;
    int unsigned seg_len;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      seg_mode = $urandom_range(0, 3);
      seg_len  = $urandom_range(8, 64);
      repeat (seg_len) begin
        @(posedge clk);
        if (holds_done < 2 && accepted_items >= 150 + 250 * holds_done) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          holds_done++;
        end else begin
          case (seg_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  initial begin
    logic [11:0] lo, hi, lo2, hi2;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_REGION_TOP;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    kind        <= KIND_LOAD;
    col         <= '0;
    row         <= '0;
    table_index <= '0;
    blue        <= '0;
    green       <= '0;
    red         <= '0;
    alpha       <= '0;
    mask_blue   <= '0;
    mask_green  <= '0;
    mask_red    <= '0;
    cur_top      = '0;
    cur_bottom   = '0;
    cur_left     = '0;
    cur_right    = '0;
    cur_strength = STRENGTH_RST;

    // Reset leaves a one-pixel rectangle at the origin at full strength.
    steps.push_back(item_step(KIND_LOAD, 12'h000, 12'h000, 18'h00000, 24'h112233,
                              8'h5A, 24'hFFFFFF));
    steps.push_back(item_step(KIND_LOAD, 12'hFFF, 12'hFFF, 18'h3FFFF, 24'h4080C0,
                              8'hFF, 24'h000000));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h3FFFF,
                                       24'h000000, 8'h00, 24'hFFFFFF), 24'h112233, 1'b1));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h00000,
                                       24'hFFFFFF, 8'hFF, 24'hFFFFFF), 24'h4080C0, 1'b1));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h00000,
                                       24'h000000, 8'h3C, 24'h000000), 24'h000000, 1'b1));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h00000,
                                       24'hFFFFFF, 8'hC3, 24'h000000), 24'hFFFFFF, 1'b1));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h001, 12'h000, 18'h00000,
                                       24'h010203, 8'h77, 24'hFFFFFF), 24'h010203, 1'b0));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h000, 12'h001, 18'h00000,
                                       24'hFFFFFF, 8'h88, 24'hFFFFFF), 24'hFFFFFF, 1'b0));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'hFFF, 12'hFFF, 18'h00000,
                                       24'hFCFDFE, 8'h01, 24'hFFFFFF), 24'hFCFDFE, 1'b0));
    steps.push_back(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h12345, 24'h020103,
                              8'h80, 24'h1080F0));
    steps.push_back(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h2AAAA, 24'hFEFDFF,
                              8'h7F, 24'h010203));
    steps.push_back(cfg_step(CFG_STRENGTH, 12'h000));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h00000,
                                       24'h030201, 8'h42, 24'hFFFFFF), 24'h030201, 1'b1));
    // Strength codes above 100 saturate at 100.
    steps.push_back(cfg_step(CFG_STRENGTH, 12'hFFF));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h00000,
                                       24'h000000, 8'h24, 24'hFFFFFF), 24'h112233, 1'b1));
    steps.push_back(cfg_step(CFG_REGION_BOTTOM, 12'hFFF));
    steps.push_back(cfg_step(CFG_REGION_RIGHT, 12'hFFF));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'hFFF, 12'hFFF, 18'h00000,
                                       24'hFFFFFF, 8'h99, 24'hFFFFFF), 24'h4080C0, 1'b1));
    steps.push_back(item_step(KIND_PIXEL, 12'h800, 12'h7FF, 18'h15555, 24'h010002,
                              8'h66, 24'h55AA7F));
    // Empty rectangles: top below bottom, then left right of right.
    steps.push_back(cfg_step(CFG_REGION_TOP, 12'hFFF));
    steps.push_back(cfg_step(CFG_REGION_BOTTOM, 12'h000));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h00000,
                                       24'h030303, 8'h11, 24'hFFFFFF), 24'h030303, 1'b0));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'hFFF, 12'hFFF, 18'h00000,
                                       24'hFFFFFF, 8'h22, 24'hFFFFFF), 24'hFFFFFF, 1'b0));
    steps.push_back(cfg_step(CFG_REGION_TOP, 12'h000));
    steps.push_back(cfg_step(CFG_REGION_BOTTOM, 12'hFFF));
    steps.push_back(cfg_step(CFG_REGION_LEFT, 12'hFFF));
    steps.push_back(cfg_step(CFG_REGION_RIGHT, 12'h000));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'h000, 12'h000, 18'h00000,
                                       24'h000000, 8'h33, 24'hFFFFFF), 24'h000000, 1'b0));
    steps.push_back(typed_as(item_step(KIND_PIXEL, 12'hFFF, 12'hFFF, 18'h00000,
                                       24'hFFFFFF, 8'h44, 24'hFFFFFF), 24'hFFFFFF, 1'b0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[k]) begin
      if (steps[k].op == STEP_CFG) begin
        settle();
        write_reg(steps[k].cfg_sel, steps[k].cfg_val);
      end else begin
        send_item(steps[k].item, steps[k].typed, steps[k].want);
        pace_sender();
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      lo  = 12'($urandom_range(0, 4094));
      hi  = 12'($urandom_range(lo + 1, 4095));
      lo2 = 12'($urandom_range(0, 4094));
      hi2 = 12'($urandom_range(lo2 + 1, 4095));
      case (ph)
        0: configure(lo, hi, lo2, hi2, 12'($urandom_range(0, 100)));
        1: configure(12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'(STRENGTH_MAX));
        2: configure(hi, lo, lo2, hi2, 12'($urandom_range(0, 100)));
        3: configure(lo, hi, lo2, hi2, 12'h000);
        4: configure(lo, hi, lo2, hi2, {5'($urandom), 7'($urandom_range(101, 127))});
        default: configure(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                           12'($urandom));
      endcase
      random_traffic(PHASE_ITEMS);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("masked_lut_recolor_pixel: match");
    end else begin
      $display("masked_lut_recolor_pixel: mismatch");
    end
    $finish;
  end

endmodule
